// ===== sv/wsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weight stability detector package
// Shared widths, register codes and control types.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FLOOR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_THRESH = 1'b1;

    localparam logic [CFG_W-1:0] WEIGHT_FLOOR_RST  = 23'd500;
    localparam logic [CFG_W-1:0] STABLE_THRESH_RST = 23'd50;

    typedef struct packed {
        logic en;
        logic first;
    } t_scan_ctl;

endpackage
`default_nettype wire

// ===== sv/wsd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/wsd_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window scan unit
// Accumulates minimum, maximum and sum over samples read one per cycle.
// ----------------------------------------------------------------------------
module wsd_scan
    import wsd_pkg::*;
#(
    parameter int SUM_W = 27
) (
    input  wire                 i_clk,
    input  t_scan_ctl           i_ctl,
    input  wire [SAMPLE_W-1:0]  i_data,
    output logic [SAMPLE_W-1:0] o_lo,
    output logic [SAMPLE_W-1:0] o_hi,
    output logic [SUM_W-1:0]    o_sum
);

    logic [SAMPLE_W-1:0] r_lo;
    logic [SAMPLE_W-1:0] r_hi;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    data_ext;

    assign data_ext = {{(SUM_W-SAMPLE_W){i_data[SAMPLE_W-1]}}, i_data};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.first) begin
                r_lo  <= i_data;
                r_hi  <= i_data;
                r_sum <= data_ext;
            end else begin
                if ($signed(i_data) < $signed(r_lo)) begin
                    r_lo <= i_data;
                end
                if ($signed(i_data) > $signed(r_hi)) begin
                    r_hi <= i_data;
                end
                r_sum <= r_sum + data_ext;
            end
        end
    end

    assign o_lo  = r_lo;
    assign o_hi  = r_hi;
    assign o_sum = r_sum;

endmodule
`default_nettype wire

// ===== sv/wsd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Floor divider by the window size
// Arithmetic shift for a power-of-two window, else a reciprocal multiply
// followed by one compare and correct step.
// ----------------------------------------------------------------------------
module wsd_div
    import wsd_pkg::*;
#(
    parameter int WINDOW_SIZE = 8
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_start,
    input  wire [SAMPLE_W+$clog2(WINDOW_SIZE)-1:0]   i_sum,
    output logic                                     o_done,
    output logic [SAMPLE_W-1:0]                      o_quot
);

    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam int SUM_W = SAMPLE_W + IDX_W;
    localparam bit POW2  = (WINDOW_SIZE & (WINDOW_SIZE - 1)) == 0;

    generate
        if (POW2) begin : g_shift
            logic                r_done;
            logic [SAMPLE_W-1:0] r_quot;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_quot <= i_sum[SUM_W-1:IDX_W];
                end
            end

            assign o_done = r_done;
            assign o_quot = r_quot;
        end else begin : g_recip
            // A negative sum is folded to its one's complement, divided as a
            // magnitude and folded back, which rounds toward minus infinity.
            // The truncated reciprocal leaves the first quotient at most one
            // short, which the remainder check corrects.
            localparam int MAG_W  = SUM_W - 1;
            localparam int PROD_W = MAG_W + SAMPLE_W;
            localparam longint unsigned RECIP_L = (64'd1 << MAG_W) / WINDOW_SIZE;
            localparam logic [MAG_W-1:0] RECIP   = MAG_W'(RECIP_L);
            localparam logic [MAG_W-1:0] DIVISOR = MAG_W'(WINDOW_SIZE);

            logic                r_v1;
            logic                r_v2;
            logic                r_v3;
            logic                r_done;
            logic                r_neg;
            logic [MAG_W-1:0]    r_mag;
            logic [SAMPLE_W-1:0] r_q0;
            logic [MAG_W-1:0]    r_rem;
            logic [SAMPLE_W-1:0] r_quot;
            logic [PROD_W-1:0]   prod;
            logic [MAG_W-1:0]    back;
            logic [SAMPLE_W-1:0] q_mag;

            assign prod  = PROD_W'(r_mag) * PROD_W'(RECIP);
            assign back  = MAG_W'(r_q0) * DIVISOR;
            assign q_mag = (r_rem >= DIVISOR) ? r_q0 + 1'b1 : r_q0;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1   <= 1'b0;
                    r_v2   <= 1'b0;
                    r_v3   <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_v1   <= i_start;
                    r_v2   <= r_v1;
                    r_v3   <= r_v2;
                    r_done <= r_v3;
                end
                if (i_start) begin
                    r_neg <= i_sum[SUM_W-1];
                    r_mag <= i_sum[SUM_W-1] ? ~i_sum[MAG_W-1:0] : i_sum[MAG_W-1:0];
                end
                if (r_v1) begin
                    r_q0 <= prod[MAG_W +: SAMPLE_W];
                end
                if (r_v2) begin
                    r_rem <= r_mag - back;
                end
                if (r_v3) begin
                    r_quot <= r_neg ? ~q_mag : q_mag;
                end
            end

            assign o_done = r_done;
            assign o_quot = r_quot;
        end
    endgenerate

endmodule
`default_nettype wire

// ===== sv/weight_stability_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weight stability detector
// Peak-to-peak stability check over a moving window of weight samples.
// ----------------------------------------------------------------------------
// Each accepted sample yields exactly one result. While the window is still
// filling, or when the sample is below the minimum weight, the item goes
// straight to the result. Otherwise the window is walked through its single
// RAM read port, one entry a cycle, and then judged. A report also waits for
// the divider: an arithmetic shift for a power-of-two window, else the
// reciprocal divider. The input is stalled while an item is being processed;
// a finished result waits in the output register.
module weight_stability_detector
    import wsd_pkg::*;
#(
    parameter int WINDOW_SIZE = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire [SAMPLE_W-1:0]   i_weight_sample,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic                 o_window_full,
    output logic                 o_is_stable,
    output logic                 o_report_valid,
    output logic [SAMPLE_W-1:0]  o_average_weight,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_W-1:0]      i_cfg_data
);

    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W = SAMPLE_W + IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_JUDGE,
        S_DIV,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic                r_was_stable, n_was_stable;
    logic [IDX_W-1:0]    r_rd_addr, n_rd_addr;
    logic                r_rd_vld;
    logic                r_rd_first;
    logic [CFG_W-1:0]    r_weight_floor;
    logic [CFG_W-1:0]    r_thresh;
    logic                r_res_full, n_res_full;
    logic                r_res_stable, n_res_stable;
    logic                r_res_report, n_res_report;
    logic [SAMPLE_W-1:0] r_res_avg, n_res_avg;
    logic                r_o_valid, n_o_valid;
    logic                r_o_full, n_o_full;
    logic                r_o_stable, n_o_stable;
    logic                r_o_report, n_o_report;
    logic [SAMPLE_W-1:0] r_o_avg, n_o_avg;

    logic                in_acc;
    logic                full_after;
    logic                below_min;
    logic                ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;
    t_scan_ctl           scan_ctl;
    logic [SAMPLE_W-1:0] win_lo;
    logic [SAMPLE_W-1:0] win_hi;
    logic [SUM_W-1:0]    win_sum;
    logic [SAMPLE_W:0]   spread;
    logic                stable;
    logic                div_start;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quot;
    logic                out_free;

    assign o_stall     = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign full_after  = r_fill >= CNT_W'(WINDOW_SIZE - 1);
    assign below_min   = $signed({i_weight_sample[SAMPLE_W-1], i_weight_sample})
                         < $signed({2'b00, r_weight_floor});
    assign ram_re      = r_state == S_SCAN;
    assign spread      = {win_hi[SAMPLE_W-1], win_hi} - {win_lo[SAMPLE_W-1], win_lo};
    assign stable      = spread < {2'b00, r_thresh};
    assign div_start   = (r_state == S_JUDGE) && stable && !r_was_stable;
    assign out_free    = !r_o_valid || !i_stall;

    assign scan_ctl.en    = r_rd_vld;
    assign scan_ctl.first = r_rd_first;

    wsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wr_idx),
        .i_wdata (i_weight_sample),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    wsd_scan #(
        .SUM_W (SUM_W)
    ) u_scan (
        .i_clk  (i_clk),
        .i_ctl  (scan_ctl),
        .i_data (ram_rdata),
        .o_lo   (win_lo),
        .o_hi   (win_hi),
        .o_sum  (win_sum)
    );

    wsd_div #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (win_sum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state      = r_state;
        n_wr_idx     = r_wr_idx;
        n_fill       = r_fill;
        n_was_stable = r_was_stable;
        n_rd_addr    = r_rd_addr;
        n_res_full   = r_res_full;
        n_res_stable = r_res_stable;
        n_res_report = r_res_report;
        n_res_avg    = r_res_avg;
        n_o_valid    = r_o_valid && i_stall;
        n_o_full     = r_o_full;
        n_o_stable   = r_o_stable;
        n_o_report   = r_o_report;
        n_o_avg      = r_o_avg;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_wr_idx = (r_wr_idx == IDX_W'(WINDOW_SIZE - 1)) ? '0
                                                                     : r_wr_idx + 1'b1;
                    n_fill   = (r_fill == CNT_W'(WINDOW_SIZE)) ? r_fill : r_fill + 1'b1;
                    n_res_report = 1'b0;
                    n_res_avg    = '0;
                    if (!full_after) begin
                        n_res_full   = 1'b0;
                        n_res_stable = r_was_stable;
                        n_state      = S_DONE;
                    end else if (below_min) begin
                        n_was_stable = 1'b0;
                        n_res_full   = 1'b1;
                        n_res_stable = 1'b0;
                        n_state      = S_DONE;
                    end else begin
                        n_rd_addr = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_rd_addr = r_rd_addr + 1'b1;
                if (r_rd_addr == IDX_W'(WINDOW_SIZE - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_JUDGE;
            end
            S_JUDGE: begin
                n_was_stable = stable;
                n_res_full   = 1'b1;
                n_res_stable = stable;
                if (div_start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res_report = 1'b1;
                    n_res_avg    = div_quot;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_full   = r_res_full;
                    n_o_stable = r_res_stable;
                    n_o_report = r_res_report;
                    n_o_avg    = r_res_avg;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_wr_idx       <= '0;
            r_fill         <= '0;
            r_was_stable   <= 1'b0;
            r_rd_addr      <= '0;
            r_rd_vld       <= 1'b0;
            r_rd_first     <= 1'b0;
            r_weight_floor <= WEIGHT_FLOOR_RST;
            r_thresh       <= STABLE_THRESH_RST;
            r_o_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wr_idx     <= n_wr_idx;
            r_fill       <= n_fill;
            r_was_stable <= n_was_stable;
            r_rd_addr    <= n_rd_addr;
            r_rd_vld     <= ram_re;
            r_rd_first   <= ram_re && (r_rd_addr == '0);
            r_o_valid    <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_WEIGHT_FLOOR:  r_weight_floor <= i_cfg_data;
                    CFG_STABLE_THRESH: r_thresh       <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_res_full   <= n_res_full;
        r_res_stable <= n_res_stable;
        r_res_report <= n_res_report;
        r_res_avg    <= n_res_avg;
        r_o_full     <= n_o_full;
        r_o_stable   <= n_o_stable;
        r_o_report   <= n_o_report;
        r_o_avg      <= n_o_avg;
    end

    assign o_valid          = r_o_valid;
    assign o_window_full    = r_o_full;
    assign o_is_stable      = r_o_stable;
    assign o_report_valid   = r_o_report;
    assign o_average_weight = r_o_avg;

`ifndef SYNTH
    a_report_needs_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_report_valid |-> o_is_stable)
        else $error("Report without stable flag.");

    a_stable_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_stable |-> o_window_full)
        else $error("Stable flag before the window is full.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("Input not stalled after a request was taken.");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW_SIZE))
        else $error("Fill count exceeds the window size.");

    a_div_only_on_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV) && r_was_stable)
        else $error("Divider finished outside a report.");
`endif

endmodule
`default_nettype wire
